// File: hdl/sct_pkg.sv
// Shared constants, reciprocal tables and the pipeline lane type for the sine/cosine block.
package sct_pkg;

    localparam int ANGLE_W      = 32;
    localparam int VALUE_W      = 32;
    localparam int SERIES_TERMS = 4;
    localparam int MAX_TERMS    = 8;
    localparam int STEP_W       = 3;

    localparam int MAG_W   = 32;
    localparam int RPROD_W = 63;
    localparam int QEST_W  = 5;
    localparam int RED_W   = 40;
    localparam int REM_W   = 35;
    localparam int ANG_W   = 36;
    localparam int X30_W   = 34;
    localparam int SQ_W    = 64;
    localparam int X2_W    = 30;
    localparam int TERM_W  = 35;
    localparam int PROD1_W = 66;
    localparam int P_W     = 38;
    localparam int RECIP_W = 28;
    localparam int PROD2_W = 67;
    localparam int ACC_W   = 40;

    localparam logic [REM_W-1:0] TWO_PI_Q32 = 35'd26986075409;
    localparam logic [REM_W-1:0] PI_Q32     = 35'd13493037705;

    // Scaled reciprocal of 2*pi for the quotient estimate: floor(2^65 / (2*pi in Q32)).
    localparam logic [30:0] RED_RECIP = 31'((96'd1 << 65) / 96'd26986075409);
    localparam int RED_SHIFT = 57;

    localparam logic [X2_W-1:0] X2_BOUND = 30'd662400000;

    localparam int RED_STAGES = 8;
    localparam int LATENCY    = RED_STAGES + 3 * SERIES_TERMS + 1;

    localparam logic [RECIP_W-1:0] RECIP_SIN [MAX_TERMS] = '{
        28'((29'd268435456 + 29'd3)   / 29'd6),
        28'((29'd268435456 + 29'd10)  / 29'd20),
        28'((29'd268435456 + 29'd21)  / 29'd42),
        28'((29'd268435456 + 29'd36)  / 29'd72),
        28'((29'd268435456 + 29'd55)  / 29'd110),
        28'((29'd268435456 + 29'd78)  / 29'd156),
        28'((29'd268435456 + 29'd105) / 29'd210),
        28'((29'd268435456 + 29'd136) / 29'd272)
    };

    localparam logic [RECIP_W-1:0] RECIP_COS [MAX_TERMS] = '{
        28'((29'd268435456 + 29'd1)   / 29'd2),
        28'((29'd268435456 + 29'd6)   / 29'd12),
        28'((29'd268435456 + 29'd15)  / 29'd30),
        28'((29'd268435456 + 29'd28)  / 29'd56),
        28'((29'd268435456 + 29'd45)  / 29'd90),
        28'((29'd268435456 + 29'd66)  / 29'd132),
        28'((29'd268435456 + 29'd91)  / 29'd182),
        28'((29'd268435456 + 29'd120) / 29'd240)
    };

    typedef struct packed {
        logic                     valid;
        logic                     is_cos;
        logic        [X2_W-1:0]   x2;
        logic signed [TERM_W-1:0] term;
        logic signed [ACC_W-1:0]  acc;
    } t_lane;

endpackage

// File: hdl/sine_cosine_taylor.sv
// Top level of the pipelined Taylor series sine and cosine unit.
//
//   Channel   Handshake        Payload
//   input     start / busy     i_opcode, i_angle (signed Q8.24)
//   result    o_done strobe    o_value (signed Q2.30)
//
// A transaction is taken on every cycle in which start is high and busy is low.
// Its result appears on o_done and o_value after range reduction and squaring, then the two
// multiplies and the accumulate of each term, and last the registered saturation.
// Busy is high only during reset, which clears every valid bit of the pipeline.
// The receiver cannot stall, so the pipeline never holds and each result shows for one cycle.
module sine_cosine_taylor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic                              i_opcode,
    input  logic signed [sct_pkg::ANGLE_W-1:0] i_angle,
    output logic                              busy,
    output logic                              o_done,
    output logic signed [sct_pkg::VALUE_W-1:0] o_value
);
    import sct_pkg::*;

    t_lane                      w_lane [SERIES_TERMS+1];
    logic                       r_done;
    logic signed [VALUE_W-1:0]  r_value;
    logic signed [VALUE_W-1:0]  n_value;

    assign busy = ~i_rst_n;

    sct_reduce u_reduce (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start & ~busy),
        .i_opcode (i_opcode),
        .i_angle  (i_angle),
        .o_lane   (w_lane[0])
    );

    for (genvar g = 0; g < SERIES_TERMS; g++) begin : g_step
        sct_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (STEP_W'(g)),
            .i_lane  (w_lane[g]),
            .o_lane  (w_lane[g+1])
        );
    end

    always_comb begin
        if (w_lane[SERIES_TERMS].acc > ACC_W'(32'sh7FFF_FFFF)) begin
            n_value = 32'sh7FFF_FFFF;
        end else if (w_lane[SERIES_TERMS].acc < ACC_W'(-33'sd2147483648)) begin
            n_value = -32'sd2147483648;
        end else begin
            n_value = w_lane[SERIES_TERMS].acc[VALUE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_lane[SERIES_TERMS].valid;
        end
    end

    assign o_done  = r_done;
    assign o_value = r_value;

`ifndef SYNTHESIS
    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching input transaction");

    a_reduced_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lane[0].valid |-> (w_lane[0].x2 <= X2_BOUND))
        else $error("reduced angle lies outside [-pi, pi]");

    a_sine_of_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(start && !busy && !i_opcode && (i_angle == 32'sd0), LATENCY))
        |-> (o_value == 32'sd0))
        else $error("sine of a zero angle is not zero");

    a_cosine_of_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(start && !busy && i_opcode && (i_angle == 32'sd0), LATENCY))
        |-> (o_value == 32'sd1073741824))
        else $error("cosine of a zero angle is not one");
`endif

endmodule

// File: hdl/sct_reduce.sv
// Range reduction of the angle to [-pi, pi] and formation of x and x squared.
module sct_reduce (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              i_opcode,
    input  logic signed [sct_pkg::ANGLE_W-1:0] i_angle,
    output sct_pkg::t_lane                    o_lane
);
    import sct_pkg::*;

    logic                     r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic                     r_s5_valid, r_s6_valid, r_s7_valid;
    logic                     r_s1_cos, r_s2_cos, r_s3_cos, r_s4_cos;
    logic                     r_s5_cos, r_s6_cos, r_s7_cos;
    logic                     r_s1_neg, r_s2_neg, r_s3_neg, r_s4_neg;
    logic        [MAG_W-1:0]   r_s1_mag, r_s2_mag;
    logic        [RPROD_W-1:0] r_s2_prod;
    logic        [RED_W-1:0]   r_s3_rem;
    logic        [REM_W-1:0]   r_s4_rem;
    logic signed [ANG_W-1:0]   r_s5_ang;
    logic signed [X30_W-1:0]   r_s6_x30, r_s7_x30;
    logic        [SQ_W-1:0]    r_s7_sq;
    t_lane                     r_lane;

    logic        [MAG_W-1:0]   n_s1_mag;
    logic        [QEST_W-1:0]  n_s3_q;
    logic        [RED_W-1:0]   n_s3_qc;
    logic        [RED_W-1:0]   n_s3_rem;
    logic        [REM_W-1:0]   n_s4_rem;
    logic signed [ANG_W-1:0]   n_s5_fold;
    logic signed [ANG_W-1:0]   n_s6_sum;
    logic signed [X30_W-1:0]   n_s7_abs;
    logic        [SQ_W-1:0]    n_s8_sum;
    t_lane                     n_lane;

    always_comb begin
        n_s1_mag = i_angle[ANGLE_W-1] ? (~$unsigned(i_angle) + 32'd1) : $unsigned(i_angle);
        n_s3_q   = r_s2_prod[RED_SHIFT+QEST_W-1:RED_SHIFT];
        n_s3_qc  = RED_W'(n_s3_q) * RED_W'(TWO_PI_Q32);
        n_s3_rem = {r_s2_mag, 8'd0} - n_s3_qc;
        if (r_s3_rem >= RED_W'(TWO_PI_Q32)) begin
            n_s4_rem = REM_W'(r_s3_rem - RED_W'(TWO_PI_Q32));
        end else begin
            n_s4_rem = r_s3_rem[REM_W-1:0];
        end
        if (r_s4_rem > PI_Q32) begin
            n_s5_fold = $signed(ANG_W'(r_s4_rem)) - $signed(ANG_W'(TWO_PI_Q32));
        end else begin
            n_s5_fold = $signed(ANG_W'(r_s4_rem));
        end
        n_s6_sum = r_s5_ang + 36'sd2;
        n_s7_abs = r_s6_x30[X30_W-1] ? -r_s6_x30 : r_s6_x30;
        n_s8_sum = r_s7_sq + 64'h0000_0002_0000_0000;

        n_lane.valid  = r_s7_valid;
        n_lane.is_cos = r_s7_cos;
        n_lane.x2     = n_s8_sum[SQ_W-1:34];
        n_lane.term   = r_s7_cos ? TERM_W'(36'sd1073741824) : TERM_W'(r_s7_x30);
        n_lane.acc    = r_s7_cos ? ACC_W'(36'sd1073741824) : ACC_W'(r_s7_x30);
    end

    always_ff @(posedge i_clk) begin
        r_s1_cos  <= i_opcode;
        r_s1_neg  <= i_angle[ANGLE_W-1];
        r_s1_mag  <= n_s1_mag;

        r_s2_cos  <= r_s1_cos;
        r_s2_neg  <= r_s1_neg;
        r_s2_mag  <= r_s1_mag;
        r_s2_prod <= RPROD_W'(r_s1_mag) * RPROD_W'(RED_RECIP);

        r_s3_cos  <= r_s2_cos;
        r_s3_neg  <= r_s2_neg;
        r_s3_rem  <= n_s3_rem;

        r_s4_cos  <= r_s3_cos;
        r_s4_neg  <= r_s3_neg;
        r_s4_rem  <= n_s4_rem;

        r_s5_cos  <= r_s4_cos;
        r_s5_ang  <= r_s4_neg ? -n_s5_fold : n_s5_fold;

        r_s6_cos  <= r_s5_cos;
        r_s6_x30  <= n_s6_sum[ANG_W-1:2];

        r_s7_cos  <= r_s6_cos;
        r_s7_x30  <= r_s6_x30;
        r_s7_sq   <= SQ_W'(n_s7_abs[MAG_W-1:0]) * SQ_W'(n_s7_abs[MAG_W-1:0]);

        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
            r_s7_valid <= 1'b0;
            r_lane     <= '0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
            r_s6_valid <= r_s5_valid;
            r_s7_valid <= r_s6_valid;
            r_lane     <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

// File: hdl/sct_step.sv
// One series term step in three stages: multiply by x squared, by the reciprocal, then accumulate.
module sct_step (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [sct_pkg::STEP_W-1:0]  i_step,
    input  sct_pkg::t_lane              i_lane,
    output sct_pkg::t_lane              o_lane
);
    import sct_pkg::*;

    t_lane                      r_a_lane, r_b_lane, r_c_lane;
    logic signed [PROD1_W-1:0]  r_a_prod;
    logic signed [PROD2_W-1:0]  r_b_prod;

    logic signed [PROD1_W-1:0]  n_b_round;
    logic signed [P_W-1:0]      n_b_p;
    logic        [RECIP_W-1:0]  n_b_recip;
    logic signed [PROD2_W-1:0]  n_c_round;
    logic signed [TERM_W-1:0]   n_c_term;
    t_lane                      n_c_lane;

    always_comb begin
        n_b_round = r_a_prod + 66'sd33554432;
        n_b_p     = n_b_round[P_W+25:26];
        n_b_recip = r_a_lane.is_cos ? RECIP_COS[i_step] : RECIP_SIN[i_step];
        n_c_round = r_b_prod + 67'sd134217728;
        n_c_term  = -n_c_round[TERM_W+27:28];

        n_c_lane      = r_b_lane;
        n_c_lane.term = n_c_term;
        n_c_lane.acc  = r_b_lane.acc + ACC_W'(n_c_term);
    end

    always_ff @(posedge i_clk) begin
        r_a_prod <= PROD1_W'(i_lane.term) * PROD1_W'($signed({1'b0, i_lane.x2}));
        r_b_prod <= PROD2_W'(n_b_p) * PROD2_W'($signed({1'b0, n_b_recip}));
        if (!i_rst_n) begin
            r_a_lane <= '0;
            r_b_lane <= '0;
            r_c_lane <= '0;
        end else begin
            r_a_lane <= i_lane;
            r_b_lane <= r_a_lane;
            r_c_lane <= n_c_lane;
        end
    end

    assign o_lane = r_c_lane;

endmodule
